/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/u8d_pkg.sv */
`default_nettype none
package u8d_pkg;

  // Byte offset counter range; the offset saturates at the smaller of
  // 2^OFFSET_WIDTH-1 and the 32-bit output field's maximum.
  localparam int OFFSET_WIDTH = 32;
  localparam logic [31:0] OFS_LIMIT = (OFFSET_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << OFFSET_WIDTH) - 64'd1);

  localparam int CP_W    = 31;
  localparam int CNT_W   = 32;
  localparam int IN_DW   = 8;
  localparam int OUT_DW  = 96;   // code point, offset, total, zero pad

  // Result queue between decoder and output stage
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [CP_W-1:0]  CP_STRICT_MAX = 31'h10_FFFF;
  localparam logic [CP_W-1:0]  CP_SURR_LO = 31'h0000_D800;
  localparam logic [CP_W-1:0]  CP_SURR_HI = 31'h0000_DFFF;

  localparam logic [7:0] B_ASCII_END = 8'h80;
  localparam logic [7:0] B_LEAD_MIN  = 8'hC0;
  localparam logic [7:0] B_LEAD3     = 8'hE0;
  localparam logic [7:0] B_LEAD4     = 8'hF0;
  localparam logic [7:0] B_LEAD5     = 8'hF8;
  localparam logic [7:0] B_LEAD6     = 8'hFC;
  localparam logic [7:0] B_BAD_MIN   = 8'hFE;
  localparam logic [7:0] B_PAY_MASK  = 8'h3F;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             decode_error;
    logic [CNT_W-1:0] char_offset;
    logic [CNT_W-1:0] char_total;
    logic             text_done;
  } u8d_result_t;

  // Queue status seen by the decoder
  typedef struct packed {
    logic full;
    logic empty;
  } u8d_qstat_t;

  // Smallest legal value for a sequence with the given continuation count
  function automatic logic [CP_W-1:0] min_for_len(input logic [2:0] cnt);
    logic [CP_W-1:0] m;
    begin
      unique case (cnt)
        3'd1:    m = 31'h0000_0080;
        3'd2:    m = 31'h0000_0800;
        3'd3:    m = 31'h0001_0000;
        3'd4:    m = 31'h0020_0000;
        3'd5:    m = 31'h0400_0000;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// Extended UTF-8 decoder: takes one text byte per beat (tlast on the final
// byte of a text) and returns one result per finished character, per first
// error of a text, and per end of text, carrying a 31-bit code point, byte
// offset of the character start and running character count. Throughput is
// one byte per clock while the result queue has room; the decoder writes each
// result into the 4-entry result queue, and the output register reads it from
// there. in_tready drops only while that queue is full. cfg_wr_en/cfg_wr_data
// set strict mode (reset 1), which also rejects values above 0x10FFFF and
// surrogates; write it only while no text is in flight.
`default_nettype none
module utf8_stream_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Byte input
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] text_byte
  input  wire logic                        in_tlast,   // end_of_text
  // Strict mode register
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  // Results
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [30:0] code_point, [62:31] char_offset, [94:63] char_total, [95] zero
  output logic [u8d_pkg::OUT_DW-1:0]       out_tdata,
  output logic                             out_tuser,  // decode_error
  output logic                             out_tlast   // text_done
);
  import u8d_pkg::*;

  u8d_qstat_t  qstat;
  logic        push, pop;
  u8d_result_t push_data, pop_data;

  u8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .qstat       (qstat),
    .push        (push),
    .push_data   (push_data)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* hw/rtl/u8d_front.sv */
`default_nettype none
module u8d_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,
  input  wire logic                        in_tlast,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire u8d_pkg::u8d_qstat_t         qstat,
  output logic                             push,
  output u8d_pkg::u8d_result_t             push_data
);
  import u8d_pkg::*;

  logic             strict_r;
  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [2:0]       remain_r, remain_nxt;
  logic [2:0]       seqlen_r, seqlen_nxt;
  logic             hold_r, hold_nxt;
  logic [CNT_W-1:0] byte_ofs_r, byte_ofs_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             acc;
  logic             fail;
  logic [2:0]       cnt;
  logic [CP_W-1:0]  v;
  logic             bad;

  // One result at most per byte, so a free queue slot is enough
  assign in_tready = !qstat.full;
  assign acc       = in_tvalid && in_tready;

  // Per-byte decode
  always_comb begin
    partial_nxt  = partial_r;
    remain_nxt   = remain_r;
    seqlen_nxt   = seqlen_r;
    hold_nxt     = hold_r;
    byte_ofs_nxt = byte_ofs_r;
    start_nxt    = start_r;
    count_nxt    = count_r;
    push         = 1'b0;
    push_data    = '0;
    fail         = 1'b0;
    cnt          = 3'd1;
    v            = {CONT_TAG, in_tdata[5:0], partial_r[22:0]};
    bad          = 1'b0;
    if (acc) begin
      if (byte_ofs_r < OFS_LIMIT) begin
        byte_ofs_nxt = byte_ofs_r + 32'd1;
      end
      if (hold_r) begin
        if (in_tlast) begin
          push      = 1'b1;
          push_data = '{code_point: '0, decode_error: 1'b1, char_offset: start_r,
                        char_total: count_r, text_done: 1'b1};
        end
      end else if (remain_r == 3'd0) begin
        start_nxt = byte_ofs_r;
        if (in_tdata < B_ASCII_END) begin
          count_nxt = (count_r == CNT_MAX) ? count_r : count_r + 32'd1;
          push      = 1'b1;
          push_data = '{code_point: {23'd0, in_tdata}, decode_error: 1'b0,
                        char_offset: byte_ofs_r, char_total: count_nxt,
                        text_done: in_tlast};
        end else if (in_tdata < B_LEAD_MIN || in_tdata >= B_BAD_MIN) begin
          fail = 1'b1;
        end else begin
          priority if (in_tdata >= B_LEAD6) cnt = 3'd5;
          else if (in_tdata >= B_LEAD5)     cnt = 3'd4;
          else if (in_tdata >= B_LEAD4)     cnt = 3'd3;
          else if (in_tdata >= B_LEAD3)     cnt = 3'd2;
          else                              cnt = 3'd1;
          partial_nxt = {23'd0, in_tdata & (B_PAY_MASK >> cnt)};
          remain_nxt  = cnt;
          seqlen_nxt  = cnt;
          fail        = in_tlast;
        end
      end else if (in_tdata[7:6] != CONT_TAG) begin
        fail = 1'b1;
      end else begin
        // Continuation: shift in six payload bits
        v           = {partial_r[CP_W-7:0], in_tdata[5:0]};
        partial_nxt = v;
        remain_nxt  = remain_r - 3'd1;
        if (remain_nxt == 3'd0) begin
          bad = (v < min_for_len(seqlen_r)) ||
                (strict_r && (v > CP_STRICT_MAX ||
                              (v >= CP_SURR_LO && v <= CP_SURR_HI)));
          if (bad) begin
            fail = 1'b1;
          end else begin
            count_nxt = (count_r == CNT_MAX) ? count_r : count_r + 32'd1;
            push      = 1'b1;
            push_data = '{code_point: v, decode_error: 1'b0, char_offset: start_r,
                          char_total: count_nxt, text_done: in_tlast};
          end
        end else if (in_tlast) begin
          fail = 1'b1;
        end
      end

      // First error of the text: report at the character start, then hold
      if (fail) begin
        push        = 1'b1;
        push_data   = '{code_point: '0, decode_error: 1'b1, char_offset: start_nxt,
                        char_total: count_nxt, text_done: in_tlast};
        hold_nxt    = 1'b1;
        remain_nxt  = 3'd0;
        partial_nxt = '0;
      end

      // End of text clears everything but the mode
      if (in_tlast) begin
        partial_nxt  = '0;
        remain_nxt   = 3'd0;
        seqlen_nxt   = 3'd0;
        hold_nxt     = 1'b0;
        byte_ofs_nxt = '0;
        start_nxt    = '0;
        count_nxt    = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r   <= 1'b1;
      partial_r  <= '0;
      remain_r   <= 3'd0;
      seqlen_r   <= 3'd0;
      hold_r     <= 1'b0;
      byte_ofs_r <= '0;
      start_r    <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        strict_r <= cfg_wr_data;
      end
      partial_r  <= partial_nxt;
      remain_r   <= remain_nxt;
      seqlen_r   <= seqlen_nxt;
      hold_r     <= hold_nxt;
      byte_ofs_r <= byte_ofs_nxt;
      start_r    <= start_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/u8d_queue.sv */
`default_nettype none
module u8d_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire u8d_pkg::u8d_result_t  push_data,
  input  wire logic                  pop,
  output u8d_pkg::u8d_result_t       pop_data,
  output u8d_pkg::u8d_qstat_t        qstat
);
  import u8d_pkg::*;

  u8d_result_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (fill_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (fill_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/u8d_back.sv */
`default_nettype none
module u8d_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire u8d_pkg::u8d_qstat_t           qstat,
  input  wire u8d_pkg::u8d_result_t          pop_data,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [u8d_pkg::OUT_DW-1:0]         out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import u8d_pkg::*;

  u8d_result_t res_r;
  logic        valid_r, valid_nxt;

  // Refill the output register when it is empty or being taken
  assign pop       = !qstat.empty && (!valid_r || out_tready);
  assign valid_nxt = pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= pop_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, res_r.char_total, res_r.char_offset, res_r.code_point};
  assign out_tuser  = res_r.decode_error;
  assign out_tlast  = res_r.text_done;

endmodule
`default_nettype wire

/* hw/rtl/u8d_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module u8d_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [u8d_pkg::OUT_DW-1:0]  out_tdata,
  input  wire logic                        out_tuser
);
  import u8d_pkg::*;

  // A stalled result beat stays offered
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped")
  // Error beats carry a zero code point
  `ASSERT_CLKD(a_err_zero_cp, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[30:0] == '0, "error beat with nonzero code point")
  // A decoded character always counts itself
  `ASSERT_CLKD(a_char_counted, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[94:63] != '0, "character beat with zero count")
  // Nothing is offered while in reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "out valid after reset")

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import u8d_pkg::*;

  typedef bit [7:0] text_t[$];

  localparam int QUIET_LIMIT = 500;
  localparam int BYTES_PER_PHASE = 65;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;   // [7:0] text_byte
  logic                 in_tlast = 1'b0;    // end_of_text
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [30:0] code_point, [62:31] char_offset, [94:63] char_total, [95] zero
  logic [OUT_DW-1:0]    out_tdata;
  logic                 out_tuser;          // decode_error
  logic                 out_tlast;          // text_done

  // Smallest legal value of a sequence with the given number of continuation bytes
  function automatic bit [31:0] seq_floor(input int cont);
    if (cont == 0) return 32'd0;
    if (cont == 1) return 32'h80;
    return 32'd1 << (5 * cont + 1);
  endfunction

  // Decoder state tracker and queue of pending results
  class utf8_char_tracker;
    bit          strict_on;
    bit [30:0]   partial;
    bit [2:0]    remaining;
    bit [2:0]    cont_len;
    bit          err_hold;
    bit [31:0]   byte_ofs;
    bit [31:0]   start_ofs;
    bit [31:0]   char_count;
    u8d_result_t pending_chars[$];
    int          errors;
    int          bytes_seen;
    int          results_checked;
    int          chars_checked;
    int          bad_checked;
    int          texts_closed;

    function new();
      strict_on = 1'b1;
      clear_text();
    endfunction

    function void clear_text();
      partial = '0;
      remaining = '0;
      cont_len = '0;
      err_hold = 1'b0;
      byte_ofs = '0;
      start_ofs = '0;
      char_count = '0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void post(bit [30:0] cp, bit err, bit [31:0] ofs, bit [31:0] total, bit done);
      u8d_result_t r;
      r.code_point = cp;
      r.decode_error = err;
      r.char_offset = ofs;
      r.char_total = total;
      r.text_done = done;
      pending_chars.push_back(r);
    endfunction

    function void bump_count();
      if (char_count != CNT_MAX) char_count++;
    endfunction

    // Advance the decoder by one accepted byte
    function void take_byte(bit [7:0] b, bit eot);
      bit [31:0] ofs;
      bit        fail;
      bit [2:0]  cnt;
      bit        bad;
      ofs = byte_ofs;
      fail = 1'b0;
      bytes_seen++;
      if (byte_ofs != OFS_LIMIT) byte_ofs++;

      if (err_hold) begin
        // only the end of text speaks while holding an error
        if (eot) post('0, 1'b1, start_ofs, char_count, 1'b1);
      end else if (remaining == 0) begin
        start_ofs = ofs;
        if (b < 8'h80) begin
          bump_count();
          post({23'd0, b}, 1'b0, ofs, char_count, eot);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
          fail = 1'b1;
        end else begin
          if (b >= 8'hFC) cnt = 3'd5;
          else if (b >= 8'hF8) cnt = 3'd4;
          else if (b >= 8'hF0) cnt = 3'd3;
          else if (b >= 8'hE0) cnt = 3'd2;
          else cnt = 3'd1;
          partial = {23'd0, b & (8'h3F >> cnt)};
          remaining = cnt;
          cont_len = cnt;
          if (eot) fail = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        fail = 1'b1;
      end else begin
        partial = {partial[24:0], b[5:0]};
        remaining = remaining - 3'd1;
        if (remaining == 0) begin
          bad = {1'b0, partial} < seq_floor(cont_len);
          if (strict_on && (partial > 31'h10FFFF ||
                            (partial >= 31'hD800 && partial <= 31'hDFFF)))
            bad = 1'b1;
          if (bad) begin
            fail = 1'b1;
          end else begin
            bump_count();
            post(partial, 1'b0, start_ofs, char_count, eot);
          end
        end else if (eot) begin
          fail = 1'b1;
        end
      end

      if (fail) begin
        post('0, 1'b1, start_ofs, char_count, eot);
        err_hold = 1'b1;
        remaining = '0;
        partial = '0;
      end
      if (eot) clear_text();
    endfunction

    // Compare one result beat against the oldest pending one
    function void match_result(bit [OUT_DW-1:0] data, bit err, bit done);
      u8d_result_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: data %h error %0d done %0d", data, err, done);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      results_checked++;
      if (want.decode_error) bad_checked++;
      else chars_checked++;
      if (want.text_done) texts_closed++;
      if (data[30:0] != want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, data[30:0]);
        errors++;
      end
      if (err != want.decode_error) begin
        $error("decode_error: expected %0d, got %0d", want.decode_error, err);
        errors++;
      end
      if (data[62:31] != want.char_offset) begin
        $error("char_offset: expected %0d, got %0d", want.char_offset, data[62:31]);
        errors++;
      end
      if (data[94:63] != want.char_total) begin
        $error("char_total: expected %0d, got %0d", want.char_total, data[94:63]);
        errors++;
      end
      if (done != want.text_done) begin
        $error("text_done: expected %0d, got %0d", want.text_done, done);
        errors++;
      end
      if (data[95] != 1'b0) begin
        $error("pad: expected 0, got %0d", data[95]);
        errors++;
      end
    endfunction
  endclass

  utf8_char_tracker tracker = new();
  text_t            text_q;
  bit               in_calm;
  bit               out_calm;
  int               out_gap;
  int               out_hold;
  int               quiet;

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: check each beat, then stall out_tready at random unless out_calm is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      tracker.match_result(out_tdata, out_tuser, out_tlast);
      out_gap = out_calm ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      out_tready <= (out_gap == 0);
      out_hold <= out_gap;
    end else if (out_hold > 1) begin
      out_hold <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
      out_hold <= 0;
    end
  end

  // Watchdog: too long with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // One byte beat after a random gap; valid stays up for the next byte
  task automatic send_byte(input bit [7:0] b, input bit eot);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b, eot);
  endtask

  task automatic send_text(input text_t bytes);
    in_calm = ($urandom_range(0, 3) == 0);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Mode change only with the decoder drained
  task automatic set_strict(input bit mode);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.strict_on = mode;
  endtask

  // Append an n-byte encoding of v to the text being built
  function automatic void encode_char(input int n, input bit [30:0] v);
    bit [7:0] lead_tag;
    if (n == 1) begin
      text_q.push_back({1'b0, v[6:0]});
      return;
    end
    lead_tag = 8'hFF << (8 - n);
    text_q.push_back(lead_tag | 8'(v >> (6 * (n - 1))));
    for (int k = n - 2; k >= 0; k--)
      text_q.push_back(8'h80 | (8'(v >> (6 * k)) & 8'h3F));
  endfunction

  // Random text: mostly well-formed characters, some broken ones
  task automatic build_random_text();
    int        nchars;
    int        kind;
    int        n;
    int        r;
    int        drop;
    bit [31:0] lo;
    bit [31:0] hi;
    bit [7:0]  b;
    text_q = {};
    nchars = $urandom_range(1, 6);
    for (int c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        r = $urandom_range(0, 99);
        n = (r < 30) ? 1 : (r < 50) ? 2 : (r < 75) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
        lo = seq_floor(n - 1);
        hi = (n == 1) ? 32'h7F : 32'((64'd1 << (5 * n + 1)) - 64'd1);
        if (n == 4 && $urandom_range(0, 9) < 7) hi = 32'h10FFFF;
        encode_char(n, 31'($urandom_range(hi, lo)));
      end else if (kind < 84) begin
        // overlong form
        n = $urandom_range(2, 6);
        encode_char(n, 31'($urandom_range(seq_floor(n - 1) - 1, 0)));
      end else if (kind < 88) begin
        text_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 91) begin
        text_q.push_back(8'($urandom_range(8'hFF, 8'hFE)));
      end else if (kind < 96) begin
        // sequence cut short by a non-continuation byte
        n = $urandom_range(2, 6);
        encode_char(n, 31'($urandom_range(32'h7FFF_FFFF, 0)));
        drop = $urandom_range(1, n - 1);
        repeat (drop) void'(text_q.pop_back());
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text_q.push_back(b);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // text ending inside a sequence
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(2, 6);
      encode_char(n, 31'($urandom_range(32'h7FFF_FFFF, 0)));
      drop = $urandom_range(1, n - 1);
      repeat (drop) void'(text_q.pop_back());
    end
  endtask

  initial begin
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // strict mode straight out of reset
    text_q = {8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(text_q);
    text_q = {8'h80, 8'h41, 8'hFF};   // stray continuation, then end during hold
    send_text(text_q);
    text_q = {8'hE0, 8'h80, 8'h80};   // overlong three-byte form
    send_text(text_q);
    text_q = {8'hED, 8'hA0, 8'h80};   // surrogate
    send_text(text_q);
    text_q = {8'hC3, 8'h41, 8'h42};   // sequence broken by ASCII
    send_text(text_q);
    text_q = {8'hF0, 8'h90};          // truncated at end of text
    send_text(text_q);
    text_q = {8'hFE};
    send_text(text_q);

    // lax mode: largest six-byte value, then a zero byte
    set_strict(1'b0);
    text_q = {8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00};
    send_text(text_q);

    // random phases alternating strict and lax
    for (int phase = 0; phase < 6; phase++) begin
      set_strict((phase % 2) == 0);
      phase_start = tracker.bytes_seen;
      while (tracker.bytes_seen - phase_start < BYTES_PER_PHASE) begin
        build_random_text();
        send_text(text_q);
      end
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes over strict and lax phases; %0d texts closed.",
             tracker.bytes_seen, tracker.texts_closed);
    $display("Checked %0d results: %0d characters, %0d error reports.",
             tracker.results_checked, tracker.chars_checked, tracker.bad_checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
